// ===== hw/rtl/sfp_pkg.sv =====
// shared types and constants for the screen frame parser
package sfp_pkg;

	// parser phase, the unused code falls back to hunting
	typedef enum logic [2:0] {
		PH_HUNT0 = 3'd0,
		PH_HUNT1 = 3'd1,
		PH_CMD   = 3'd2,
		PH_LEN   = 3'd3,
		PH_FILE  = 3'd4,
		PH_PIC   = 3'd6,
		PH_TRAIL = 3'd7
	} phase_t;

	// classification of one received byte
	localparam logic [2:0] BK_IGNORE  = 3'd0;
	localparam logic [2:0] BK_CMD     = 3'd1;
	localparam logic [2:0] BK_LEN     = 3'd2;
	localparam logic [2:0] BK_PAYLOAD = 3'd3;
	localparam logic [2:0] BK_TRAIL   = 3'd4;

	// frame kinds
	localparam logic [1:0] FK_OTHER    = 2'd0;
	localparam logic [1:0] FK_PICTURE  = 2'd1;
	localparam logic [1:0] FK_DOWNLOAD = 2'd2;

	// command codes
	localparam logic [7:0] CMD_PREFIX   = 8'h00;
	localparam logic [7:0] CMD_PICTURE  = 8'h03;
	localparam logic [7:0] CMD_DOWNLOAD = 8'h10;

	// configuration register indexes and reset values
	localparam logic [1:0] REG_SYNC  = 2'd0;
	localparam logic [1:0] REG_END   = 2'd1;
	localparam logic [1:0] REG_LIMIT = 2'd2;

	localparam logic [7:0]  SYNC_RESET  = 8'h5a;
	localparam logic [7:0]  END_RESET   = 8'ha5;
	localparam logic [12:0] LIMIT_RESET = 13'h1fff;

	// configuration as seen by the parser core
	typedef struct packed {
		logic [7:0]  sync_byte;
		logic [7:0]  end_byte;
		logic [12:0] length_limit;
	} cfg_t;

	// one result item
	typedef struct packed {
		logic [2:0]  byte_kind;
		logic [7:0]  data_byte;
		logic [12:0] byte_index;
		logic        download_start;
		logic [1:0]  frame_kind;
		logic [12:0] payload_length;
		logic        frame_end;
		logic        frame_good;
		logic        frame_rejected;
	} res_t;

endpackage

// ===== hw/rtl/sfp_fsm.sv =====
// frame parser state machine: classifies one byte per step
module sfp_fsm #(
	parameter int CMD_BYTES = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  sfp_pkg::cfg_t       cfg,
	output sfp_pkg::res_t       res
);

	localparam logic [12:0] CMD_LAST = 13'(CMD_BYTES);

	sfp_pkg::phase_t phase_q, phase_d;
	logic [12:0] byte_count_q, byte_count_d;
	logic [12:0] expected_q, expected_d;
	logic [7:0]  cmd_first_q, cmd_first_d;
	logic [7:0]  cmd_second_q, cmd_second_d;
	logic [7:0]  length_high_q, length_high_d;
	logic [1:0]  kind_q, kind_d;

	logic [12:0] cnt_inc;
	logic        cmd_last;
	logic [12:0] pic_len;
	logic [12:0] exp_cmd;
	logic        is_pic;
	logic        is_dl;
	logic [16:0] total;
	logic        too_long;
	logic        sync_hit;

	// shared helpers
	assign cnt_inc  = byte_count_q + 13'd1;
	assign cmd_last = (cnt_inc >= CMD_LAST);
	assign pic_len  = (rx_byte == 8'd0) ? 13'd0 : ({3'd0, rx_byte, 2'b00} - 13'd1);
	assign exp_cmd  = (byte_count_q == 13'd2) ? pic_len : expected_q;
	assign is_pic   = (cmd_first_q == sfp_pkg::CMD_PREFIX) &&
	                  (cmd_second_q == sfp_pkg::CMD_PICTURE);
	assign is_dl    = (cmd_first_q == sfp_pkg::CMD_PREFIX) &&
	                  (cmd_second_q == sfp_pkg::CMD_DOWNLOAD);
	assign total    = {1'b0, length_high_q, rx_byte} + 17'd2;
	assign too_long = (total >= {4'd0, cfg.length_limit});
	assign sync_hit = (rx_byte == cfg.sync_byte);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			sfp_pkg::PH_HUNT0: begin
				phase_d = sync_hit ? sfp_pkg::PH_HUNT1 : sfp_pkg::PH_HUNT0;
			end
			sfp_pkg::PH_HUNT1: begin
				phase_d = sync_hit ? sfp_pkg::PH_CMD : sfp_pkg::PH_HUNT0;
			end
			sfp_pkg::PH_CMD: begin
				if (cmd_last) begin
					if (is_pic) begin
						phase_d = (exp_cmd == 13'd0) ? sfp_pkg::PH_TRAIL : sfp_pkg::PH_PIC;
					end else if (is_dl) begin
						phase_d = sfp_pkg::PH_LEN;
					end else begin
						phase_d = sfp_pkg::PH_TRAIL;
					end
				end
			end
			sfp_pkg::PH_LEN: begin
				if (byte_count_q != 13'd0) begin
					if (too_long) begin
						phase_d = sfp_pkg::PH_HUNT0;
					end else if (total == 17'd2) begin
						phase_d = sfp_pkg::PH_TRAIL;
					end else begin
						phase_d = sfp_pkg::PH_FILE;
					end
				end
			end
			sfp_pkg::PH_FILE, sfp_pkg::PH_PIC: begin
				if (cnt_inc >= expected_q) phase_d = sfp_pkg::PH_TRAIL;
			end
			sfp_pkg::PH_TRAIL: begin
				phase_d = sfp_pkg::PH_HUNT0;
			end
			default: begin
				phase_d = sfp_pkg::PH_HUNT0;
			end
		endcase
	end

	// result fields and datapath updates
	always_comb begin
		res            = '0;
		res.data_byte  = rx_byte;
		byte_count_d   = byte_count_q;
		expected_d     = expected_q;
		cmd_first_d    = cmd_first_q;
		cmd_second_d   = cmd_second_q;
		length_high_d  = length_high_q;
		kind_d         = kind_q;
		unique case (phase_q)
			sfp_pkg::PH_CMD: begin
				res.byte_kind  = sfp_pkg::BK_CMD;
				res.byte_index = byte_count_q;
				if (byte_count_q == 13'd0) cmd_first_d = rx_byte;
				if (byte_count_q == 13'd1) cmd_second_d = rx_byte;
				expected_d   = exp_cmd;
				byte_count_d = cnt_inc;
				if (cmd_last) begin
					byte_count_d = 13'd0;
					if (is_pic) begin
						kind_d             = sfp_pkg::FK_PICTURE;
						res.payload_length = exp_cmd;
					end else if (is_dl) begin
						kind_d             = sfp_pkg::FK_DOWNLOAD;
						expected_d         = 13'd0;
						res.download_start = 1'b1;
					end else begin
						kind_d     = sfp_pkg::FK_OTHER;
						expected_d = 13'd0;
					end
					res.frame_kind = kind_d;
				end
			end
			sfp_pkg::PH_LEN: begin
				res.byte_kind  = sfp_pkg::BK_LEN;
				res.byte_index = byte_count_q;
				res.frame_kind = kind_q;
				if (byte_count_q == 13'd0) begin
					length_high_d = rx_byte;
					byte_count_d  = 13'd1;
				end else if (too_long) begin
					res.frame_rejected = 1'b1;
					expected_d         = 13'd0;
					byte_count_d       = 13'd0;
				end else begin
					expected_d         = total[12:0];
					res.payload_length = total[12:0];
					byte_count_d       = 13'd2;
				end
			end
			sfp_pkg::PH_FILE, sfp_pkg::PH_PIC: begin
				res.byte_kind      = sfp_pkg::BK_PAYLOAD;
				res.byte_index     = byte_count_q;
				res.frame_kind     = kind_q;
				res.payload_length = expected_q;
				byte_count_d       = cnt_inc;
			end
			sfp_pkg::PH_TRAIL: begin
				res.byte_kind      = sfp_pkg::BK_TRAIL;
				res.frame_end      = 1'b1;
				res.frame_good     = (rx_byte == cfg.end_byte);
				res.frame_kind     = kind_q;
				res.payload_length = expected_q;
				byte_count_d       = 13'd0;
			end
			default: begin
				byte_count_d = 13'd0;
			end
		endcase
	end

	// parser state, advanced once per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= sfp_pkg::PH_HUNT0;
			byte_count_q  <= '0;
			expected_q    <= '0;
			cmd_first_q   <= '0;
			cmd_second_q  <= '0;
			length_high_q <= '0;
			kind_q        <= '0;
		end else if (step) begin
			phase_q       <= phase_d;
			byte_count_q  <= byte_count_d;
			expected_q    <= expected_d;
			cmd_first_q   <= cmd_first_d;
			cmd_second_q  <= cmd_second_d;
			length_high_q <= length_high_d;
			kind_q        <= kind_d;
		end
	end

endmodule

// ===== hw/rtl/screen_frame_parser_unit.sv =====
// top level of the screen frame parser: config registers, parser core, result register
//
// channel  direction  handshake            payload
// in       receive    in_valid / in_stall  rx_byte
// out      send       out_valid/out_stall  byte_kind .. frame_rejected (9 fields)
// cfg      receive    cfg_we               cfg_index, cfg_data
//
// every accepted item yields one result item, registered in the cycle after; one item per cycle
// sustained while out_stall is low, set by the single state update of the parser core per byte.
// in_stall is high only while a result waits in the output register and out_stall
// holds it; a result taken in the same cycle frees the register for the next item.
// reset clears the parser state, the output valid and restores the register defaults.
module screen_frame_parser_unit #(
	parameter int CMD_BYTES = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  byte_kind,
	output logic [7:0]  data_byte,
	output logic [12:0] byte_index,
	output logic        download_start,
	output logic [1:0]  frame_kind,
	output logic [12:0] payload_length,
	output logic        frame_end,
	output logic        frame_good,
	output logic        frame_rejected,
	// configuration port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	sfp_pkg::cfg_t cfg_q;
	sfp_pkg::res_t res;
	sfp_pkg::res_t res_q;
	logic          out_valid_q;
	logic          step;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte    <= sfp_pkg::SYNC_RESET;
			cfg_q.end_byte     <= sfp_pkg::END_RESET;
			cfg_q.length_limit <= sfp_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				sfp_pkg::REG_SYNC:  cfg_q.sync_byte    <= cfg_data[7:0];
				sfp_pkg::REG_END:   cfg_q.end_byte     <= cfg_data[7:0];
				sfp_pkg::REG_LIMIT: cfg_q.length_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	// input handshake
	assign in_stall = out_valid_q & out_stall;
	assign step     = in_valid & ~in_stall;

	// parser core
	sfp_fsm #(
		.CMD_BYTES (CMD_BYTES)
	) u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (rx_byte),
		.cfg     (cfg_q),
		.res     (res)
	);

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= step | (out_valid_q & out_stall);
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	// output ports
	assign out_valid      = out_valid_q;
	assign byte_kind      = res_q.byte_kind;
	assign data_byte      = res_q.data_byte;
	assign byte_index     = res_q.byte_index;
	assign download_start = res_q.download_start;
	assign frame_kind     = res_q.frame_kind;
	assign payload_length = res_q.payload_length;
	assign frame_end      = res_q.frame_end;
	assign frame_good     = res_q.frame_good;
	assign frame_rejected = res_q.frame_rejected;

endmodule
